@@ rtl/core/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

  // fixed field widths of the result and configuration ports
  localparam int ROW_IDX_W = 6;
  localparam int ROW_RES_W = 40;
  localparam int ALPHA_W   = 61;
  localparam int CFG_W     = 7;

  // vector length after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_write;  // store v and v+w of a load request
    logic capture;     // register a matrix request and read both stores
    logic mul_en;      // load the shared product register
    logic mul_alpha;   // product is v_i * u_i instead of (a+b) * t_k
    logic acc_row;     // add product into the row sum
    logic acc_alpha;   // add product into alpha
    logic clr_row;     // clear the row sum
    logic clr_alpha;   // clear alpha
  } dp_cmd_t;

endpackage

@@ rtl/core/bfa_datapath.sv @@
`timescale 1ns / 1ps

module bfa_datapath
  import bfa_pkg::*;
#(
  parameter int MAX_LENGTH = 64,
  parameter int DATA_WIDTH = 16,
  parameter int IDX_W      = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic [IDX_W-1:0]             col_addr,
  input  logic [IDX_W-1:0]             row_addr,
  input  logic signed [DATA_WIDTH-1:0] first_value,
  input  logic signed [DATA_WIDTH-1:0] second_value,
  output logic signed [ROW_RES_W-1:0]  row_result,
  output logic signed [ALPHA_W-1:0]    running_alpha
);

  localparam int SUM_W  = DATA_WIDTH + 1;
  localparam int ACC_W  = 2 * SUM_W + $clog2(MAX_LENGTH);
  localparam int PROD_W = SUM_W + ACC_W;

  logic signed [DATA_WIDTH-1:0] v_mem   [MAX_LENGTH];
  logic signed [SUM_W-1:0]      sum_mem [MAX_LENGTH];

  logic signed [DATA_WIDTH-1:0] a_q;
  logic signed [DATA_WIDTH-1:0] b_q;
  logic signed [SUM_W-1:0]      t_q;
  logic signed [DATA_WIDTH-1:0] vr_q;
  logic signed [SUM_W-1:0]      load_sum;
  logic signed [SUM_W-1:0]      ab_sum;
  logic signed [SUM_W-1:0]      mul_x;
  logic signed [ACC_W-1:0]      mul_y;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      row_acc;
  logic signed [ALPHA_W-1:0]    alpha_acc;

  assign load_sum = SUM_W'(first_value) + SUM_W'(second_value);
  assign ab_sum   = SUM_W'(a_q) + SUM_W'(b_q);

  // vector stores, written in the load phase
  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      v_mem[col_addr]   <= first_value;
      sum_mem[col_addr] <= load_sum;
    end
  end

  // matrix request capture with registered store reads
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_q  <= first_value;
      b_q  <= second_value;
      t_q  <= sum_mem[col_addr];
      vr_q <= v_mem[row_addr];
    end
  end

  // shared multiplier operand select
  assign mul_x = cmd.mul_alpha ? SUM_W'(vr_q) : ab_sum;
  assign mul_y = cmd.mul_alpha ? row_acc : ACC_W'(t_q);

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= mul_x * mul_y;
    end
  end

  // row sum and alpha accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_row) begin
      row_acc <= '0;
    end else if (cmd.acc_row) begin
      row_acc <= row_acc + ACC_W'(prod_q);
    end
    if (rst || cmd.clr_alpha) begin
      alpha_acc <= '0;
    end else if (cmd.acc_alpha) begin
      alpha_acc <= alpha_acc + ALPHA_W'(prod_q);
    end
  end

  assign row_result    = ROW_RES_W'(row_acc);
  assign running_alpha = alpha_acc;

endmodule

@@ rtl/core/bfa_control.sv @@
`timescale 1ns / 1ps

module bfa_control
  import bfa_pkg::*;
#(
  parameter int MAX_LENGTH = 64,
  parameter int IDX_W      = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 config_we,
  input  logic [CFG_W-1:0]     config_data,
  output logic                 busy,
  output logic                 done,
  output logic                 last,
  output logic [ROW_IDX_W-1:0] row_index,
  output logic [IDX_W-1:0]     col_addr,
  output logic [IDX_W-1:0]     row_addr,
  output dp_cmd_t              cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_AMUL = 3'd3;
  localparam logic [2:0] S_AACC = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CFG_W-1:0] vlen;
  logic             load_phase;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] emit_row;
  logic             row_end_q;
  logic             last_q;
  logic [IDX_W-1:0] last_idx;
  logic             accept;
  logic             col_end;
  logic             row_last;

  // last valid index from the configured length, clamped to 1..MAX_LENGTH
  always_comb begin
    if (vlen == '0) begin
      last_idx = '0;
    end else if (32'(vlen) > MAX_LENGTH) begin
      last_idx = IDX_W'(MAX_LENGTH - 1);
    end else begin
      last_idx = IDX_W'(32'(vlen) - 1);
    end
  end

  assign col_end  = (col == last_idx);
  assign row_last = (row == last_idx);

  // ready again while the row sum of a mid-row request is being added, never in reset
  assign busy   = rst || !((state == S_IDLE) || ((state == S_ACC) && !row_end_q));
  assign accept = start && !busy;

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.load_write = accept && load_phase;
    cmd.capture    = accept && !load_phase;
    cmd.mul_en     = (state == S_MUL) || (state == S_AMUL);
    cmd.mul_alpha  = (state == S_AMUL);
    cmd.acc_row    = (state == S_ACC);
    cmd.acc_alpha  = (state == S_AACC);
    cmd.clr_row    = config_we || (state == S_EMIT);
    cmd.clr_alpha  = config_we || ((state == S_EMIT) && last_q);
  end

  assign col_addr = col;
  assign row_addr = row;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !load_phase) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (row_end_q) begin
          state_next = S_AMUL;
        end else if (accept) begin
          state_next = S_MUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_AMUL: begin
        state_next = S_AACC;
      end
      S_AACC: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // length register, phase and element counters
  always_ff @(posedge clk) begin
    if (rst) begin
      vlen       <= CFG_RESET;
      load_phase <= 1'b1;
      col        <= '0;
      row        <= '0;
      emit_row   <= '0;
      row_end_q  <= 1'b0;
      last_q     <= 1'b0;
    end else if (config_we) begin
      vlen       <= config_data;
      load_phase <= 1'b1;
      col        <= '0;
      row        <= '0;
    end else if (accept) begin
      if (load_phase) begin
        if (col_end) begin
          load_phase <= 1'b0;
          col        <= '0;
          row        <= '0;
        end else begin
          col <= col + 1'b1;
        end
      end else begin
        row_end_q <= col_end;
        last_q    <= row_last;
        emit_row  <= row;
        if (col_end) begin
          col <= '0;
          if (row_last) begin
            row        <= '0;
            load_phase <= 1'b1;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  assign done      = (state == S_EMIT);
  assign last      = last_q;
  assign row_index = ROW_IDX_W'(emit_row);

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("request accepted while a result is shown");
  a_last_reload: assert property (@(posedge clk) disable iff (rst) (done && last) |-> load_phase)
    else $error("final row without return to the load phase");
  a_capture_mul: assert property (@(posedge clk) disable iff (rst) cmd.capture |=> (state == S_MUL))
    else $error("matrix request not followed by a multiply");
  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= last_idx)
    else $error("column counter beyond vector length");
`endif

endmodule

@@ rtl/core/bilinear_form_accumulator_core.sv @@
`timescale 1ns / 1ps
// load request (v_i, w_i): busy stays low, no result
// matrix request mid-row: through the shared multiply then row-sum add, next one taken during the add
// row-end request: multiply, row-sum add, alpha multiply and alpha add states, then the result strobe (done),
//   busy throughout while the same multiplier forms v_i * u_i for alpha
// the receiver cannot stall; each result is shown for one cycle only
// synchronous reset rst: length 4, load phase, counters and accumulators cleared

module bilinear_form_accumulator_core
  import bfa_pkg::*;
#(
  parameter int MAX_LENGTH = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] first_value,
  input  logic signed [DATA_WIDTH-1:0] second_value,
  input  logic                         config_we,
  input  logic [CFG_W-1:0]             config_data,
  output logic                         done,
  output logic [ROW_IDX_W-1:0]         row_index,
  output logic signed [ROW_RES_W-1:0]  row_result,
  output logic signed [ALPHA_W-1:0]    running_alpha,
  output logic                         last
);

  localparam int IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  dp_cmd_t          cmd;
  logic [IDX_W-1:0] col_addr;
  logic [IDX_W-1:0] row_addr;

  // sequencing and counters
  bfa_control #(
    .MAX_LENGTH (MAX_LENGTH),
    .IDX_W      (IDX_W)
  ) u_control (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .config_we   (config_we),
    .config_data (config_data),
    .busy        (busy),
    .done        (done),
    .last        (last),
    .row_index   (row_index),
    .col_addr    (col_addr),
    .row_addr    (row_addr),
    .cmd         (cmd)
  );

  // stores, shared multiplier and accumulators
  bfa_datapath #(
    .MAX_LENGTH (MAX_LENGTH),
    .DATA_WIDTH (DATA_WIDTH),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .col_addr      (col_addr),
    .row_addr      (row_addr),
    .first_value   (first_value),
    .second_value  (second_value),
    .row_result    (row_result),
    .running_alpha (running_alpha)
  );

endmodule

@@ dv/bilinear_form_accumulator_core_test.sv @@
`timescale 1ns / 1ps

module bilinear_form_accumulator_core_test;
  import bfa_pkg::*;

  localparam int DW         = 16;
  localparam int MAX_LEN    = 64;
  localparam int SETTLE     = 12;
  localparam int LIMIT      = 500000;
  localparam int RAND_ITEMS = 380;

  typedef struct packed {
    logic signed [DW-1:0] first;
    logic signed [DW-1:0] second;
  } pair_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]        idx;
    logic signed [ROW_RES_W-1:0] res;
    logic signed [ALPHA_W-1:0]   alpha;
    logic                        fin;
  } row_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [DW-1:0] first_value = '0;
  logic signed [DW-1:0] second_value = '0;
  logic                 config_we = 1'b0;
  logic [CFG_W-1:0]     config_data = CFG_RESET;
  logic                 done;
  logic [ROW_IDX_W-1:0] row_index;
  logic signed [ROW_RES_W-1:0] row_result;
  logic signed [ALPHA_W-1:0]   running_alpha;
  logic                 last;

  bilinear_form_accumulator_core #(
    .MAX_LENGTH(MAX_LEN),
    .DATA_WIDTH(DW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_value(first_value),
    .second_value(second_value),
    .config_we(config_we),
    .config_data(config_data),
    .done(done),
    .row_index(row_index),
    .row_result(row_result),
    .running_alpha(running_alpha),
    .last(last)
  );

  always #1 clk = ~clk;

  // requests waiting to be sent and rows still to come back
  pair_t    pending_pairs[$];
  row_out_t expected_rows[$];
  int       failures = 0;
  int       cycle_count = 0;
  int       idle_left = 0;
  bit       idle_on = 1'b1;

  // own copy of the block state
  logic [CFG_W-1:0]       len_reg;
  logic signed [DW-1:0]   v_mem [MAX_LEN];
  logic signed [DW:0]     t_mem [MAX_LEN];
  bit                     loading;
  int unsigned            row_cnt;
  int unsigned            col_cnt;
  longint                 row_acc;
  longint                 alpha_acc;

  function automatic int unsigned length_in_use();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return len_reg;
  endfunction

  function automatic void restart_problem();
    loading   = 1'b1;
    row_cnt   = 0;
    col_cnt   = 0;
    row_acc   = 0;
    alpha_acc = 0;
  endfunction

  // one accepted request: store the vectors or add into the row sum
  function automatic void accumulate_pair(input pair_t p);
    int unsigned        m;
    logic signed [DW:0] s;
    row_out_t           r;
    m = length_in_use();
    s = p.first + p.second;
    if (loading) begin
      v_mem[col_cnt] = p.first;
      t_mem[col_cnt] = s;
      if (col_cnt + 1 >= m) begin
        loading = 1'b0;
        col_cnt = 0;
        row_cnt = 0;
      end else begin
        col_cnt++;
      end
      return;
    end
    row_acc += longint'(s) * longint'(t_mem[col_cnt]);
    if (col_cnt + 1 < m) begin
      col_cnt++;
      return;
    end
    // row end: fold v_i * u_i into alpha
    alpha_acc += longint'(v_mem[row_cnt]) * row_acc;
    r.idx   = row_cnt[ROW_IDX_W-1:0];
    r.res   = row_acc[ROW_RES_W-1:0];
    r.alpha = alpha_acc[ALPHA_W-1:0];
    r.fin   = (row_cnt + 1 >= m);
    expected_rows.push_back(r);
    row_acc = 0;
    col_cnt = 0;
    if (r.fin) restart_problem();
    else row_cnt++;
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return {1'b1, {(DW-1){1'b0}}};
      1: return {1'b0, {(DW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return r[DW-1:0];
    endcase
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      pending_pairs.push_back('{pick_value(), pick_value()});
    end
  endtask

  task automatic push_pair(input int a, input int b);
    pending_pairs.push_back('{a[DW-1:0], b[DW-1:0]});
  endtask

  // wait until every request is sent and every row is back, then let the block drain
  task automatic settle();
    while (pending_pairs.size() != 0 || start || expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] code);
    settle();
    config_we   <= 1'b1;
    config_data <= code;
    @(posedge clk);
    config_we <= 1'b0;
    len_reg = code;
    restart_problem();
  endtask

  // request driver with random idle bursts
  always @(posedge clk) begin : drive_proc
    bit took;
    bit rest_now;
    if (rst) begin
      start     <= 1'b0;
      idle_left = 0;
    end else begin
      took = start && !busy;
      if (took) accumulate_pair(pending_pairs.pop_front());
      rest_now = 1'b0;
      if (idle_left > 0) begin
        idle_left--;
        rest_now = 1'b1;
      end else if ((took || !start) && idle_on && pending_pairs.size() != 0 &&
                   $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(0, 3);
        rest_now  = 1'b1;
      end
      if (!rest_now && pending_pairs.size() != 0) begin
        start        <= 1'b1;
        first_value  <= pending_pairs[0].first;
        second_value <= pending_pairs[0].second;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_proc
    row_out_t want;
    if (!rst && done) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected result: row_index %0d", row_index);
        failures++;
      end else begin
        want = expected_rows.pop_front();
        if (row_index !== want.idx) begin
          $error("row_index expected %0d got %0d", want.idx, row_index);
          failures++;
        end
        if (row_result !== want.res) begin
          $error("row_result expected %0d got %0d", want.res, row_result);
          failures++;
        end
        if (running_alpha !== want.alpha) begin
          $error("running_alpha expected %0d got %0d", want.alpha, running_alpha);
          failures++;
        end
        if (last !== want.fin) begin
          $error("last expected %0d got %0d", want.fin, last);
          failures++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("bilinear_form_accumulator_core_test NOT OK");
      $finish;
    end
  end

  initial begin : stim_proc
    int          rand_items;
    int          m;
    int          n;
    int          sel;
    logic [CFG_W-1:0] code;
    len_reg = CFG_RESET;
    restart_problem();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset length of 4: extreme vectors, then extreme matrix entries
    push_pair(-32768, -32768);
    push_pair(32767, 32767);
    push_pair(-32768, 32767);
    push_pair(0, -1);
    for (int k = 0; k < 4; k++) push_pair(32767, 32767);
    for (int k = 0; k < 4; k++) push_pair(-32768, -32768);
    push_pair(-32768, 32767);
    push_pair(32767, -32768);
    push_pair(0, 0);
    push_pair(-1, -1);
    push_random(4);

    // shortest length, and zero acting as one
    write_length(1);
    push_random(4);
    write_length(0);
    push_random(4);

    // full length, load and the first two rows
    write_length(MAX_LEN);
    push_random(MAX_LEN + 2 * MAX_LEN);

    // oversize length acts as the maximum; one row then cut off by the next write
    write_length({CFG_W{1'b1}});
    push_random(2 * MAX_LEN + 10);

    // restart in the middle of a load phase
    write_length(3);
    push_random(2);

    // random lengths, mostly small, some problems cut short
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) m = $urandom_range(1, 6);
      else if (sel < 19) m = $urandom_range(7, 12);
      else m = $urandom_range(13, 20);
      code = m[CFG_W-1:0];
      if (m == 1 && $urandom_range(0, 1) == 1) code = '0;
      write_length(code);
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(1, 3) * (m + m * m);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      push_random(n);
      rand_items += n;
    end

    // closing stretch at full rate
    idle_on = 1'b0;
    write_length(5);
    push_random(2 * (5 + 25));
    settle();

    if (failures == 0) begin
      $display("bilinear_form_accumulator_core_test OK");
    end else begin
      $display("bilinear_form_accumulator_core_test NOT OK");
    end
    $finish;
  end

endmodule
